FILE: rtl/rtte_pkg.sv
// ----------------------------------------------------------------------------
// RTT estimator package
// Operation codes, configuration register indexes and fixed constants shared
// by the estimator modules.
// ----------------------------------------------------------------------------
package rtte_pkg;

    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0] PTO_FLOOR = 32'd1000;
    localparam logic [CFG_W-1:0]   MAX_ACK_DELAY_RST = 24'd25000;
    localparam logic [CFG_W-1:0]   INITIAL_RTT_RST   = 24'd333000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACK_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTT   = 2'd1;

    typedef enum logic [2:0] {
        OP_UPDATE  = 3'd0,
        OP_SET_INIT = 3'd1,
        OP_MIGRATE = 3'd2,
        OP_EXPIRE  = 3'd3,
        OP_QUERY   = 3'd4
    } t_op;

    typedef struct packed {
        logic valid;
        logic include_ack_delay;
    } t_stage_ctl;

endpackage

FILE: rtl/rtt_estimator.sv
// ----------------------------------------------------------------------------
// RTT estimator top level
// Throughput: one request per cycle; input register, state update, output
// register, all advancing together while the output is free or being taken.
// Reset: synchronous, active low; clears all RTT state and the pipeline and
// restores both configuration registers to their defaults.
// ----------------------------------------------------------------------------
module rtt_estimator
    import rtte_pkg::*;
#(
    parameter int unsigned ALPHA_SHIFT = 3,
    parameter int unsigned BETA_SHIFT  = 2,
    parameter int unsigned TIME_WIDTH  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // rtt_sample, peer_ack_delay, initial_value, include_ack_delay, zero pad
    input  logic [103:0]         i_s_tdata,
    // operation
    input  logic [2:0]           i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // minimum_rtt, latest_rtt, smoothed_rtt, rtt_deviation, probe_timeout
    output logic [159:0]         o_m_tdata,
    // sample_accepted
    output logic [0:0]           o_m_tuser
);

    logic [CFG_W-1:0] r_max_ack_delay, r_initial_rtt;

    logic               en;
    t_stage_ctl         r_s1, r_s2;
    t_op                r_s1_op;
    logic [FIELD_W-1:0] r_s1_sample, r_s1_ack, r_s1_init;

    logic [TIME_WIDTH-1:0] min_rtt, latest_rtt, srtt, dev;
    logic                  taken;
    logic [FIELD_W-1:0]    pto;

    logic         r_out_valid;
    logic [159:0] r_out_data;
    logic         r_out_taken;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ack_delay <= MAX_ACK_DELAY_RST;
            r_initial_rtt   <= INITIAL_RTT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ACK_DELAY: r_max_ack_delay <= i_cfg_wdata;
                CFG_INITIAL_RTT:   r_initial_rtt   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1.valid             <= i_s_tvalid;
            r_s1.include_ack_delay <= i_s_tdata[96];
            r_s2                   <= r_s1;
            r_out_valid            <= r_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_s_tvalid) begin
            r_s1_op     <= t_op'(i_s_tuser);
            r_s1_sample <= i_s_tdata[31:0];
            r_s1_ack    <= i_s_tdata[63:32];
            r_s1_init   <= i_s_tdata[95:64];
        end
        if (en && r_s2.valid) begin
            r_out_data  <= {pto, FIELD_W'(dev), FIELD_W'(srtt),
                            FIELD_W'(latest_rtt), FIELD_W'(min_rtt)};
            r_out_taken <= taken;
        end
    end

    rtte_core #(
        .ALPHA_SHIFT(ALPHA_SHIFT),
        .BETA_SHIFT (BETA_SHIFT),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en && r_s1.valid),
        .i_op          (r_s1_op),
        .i_sample      (r_s1_sample),
        .i_ack_delay   (r_s1_ack),
        .i_initial     (r_s1_init),
        .o_min_rtt     (min_rtt),
        .o_latest_rtt  (latest_rtt),
        .o_smoothed_rtt(srtt),
        .o_deviation   (dev),
        .o_taken       (taken)
    );

    rtte_pto #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_pto (
        .i_smoothed_rtt     (srtt),
        .i_deviation        (dev),
        .i_max_ack_delay    (r_max_ack_delay),
        .i_initial_rtt      (r_initial_rtt),
        .i_include_ack_delay(r_s2.include_ack_delay),
        .o_pto              (pto)
    );

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_taken;

endmodule

FILE: rtl/rtte_core.sv
// ----------------------------------------------------------------------------
// RTT estimator state update
// Holds the minimum, latest, smoothed and deviation registers and applies one
// event per enabled cycle.
// ----------------------------------------------------------------------------
module rtte_core
    import rtte_pkg::*;
#(
    parameter int unsigned ALPHA_SHIFT = 3,
    parameter int unsigned BETA_SHIFT  = 2,
    parameter int unsigned TIME_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_op                   i_op,
    input  logic [FIELD_W-1:0]    i_sample,
    input  logic [FIELD_W-1:0]    i_ack_delay,
    input  logic [FIELD_W-1:0]    i_initial,
    output logic [TIME_WIDTH-1:0] o_min_rtt,
    output logic [TIME_WIDTH-1:0] o_latest_rtt,
    output logic [TIME_WIDTH-1:0] o_smoothed_rtt,
    output logic [TIME_WIDTH-1:0] o_deviation,
    output logic                  o_taken
);

    localparam int unsigned TW = TIME_WIDTH;

    logic [TW-1:0] r_min, r_latest, r_srtt, r_dev;
    logic [TW-1:0] n_min, n_latest, n_srtt, n_dev;
    logic          r_has_meas, n_has_meas;
    logic          r_taken, n_taken;

    logic [TW-1:0] s, ack, min_upd, adj, dist_s, dist_e;
    logic [TW:0]   dev_ewma, srtt_ewma;
    logic          reject;

    always_comb begin
        s       = TW'(i_sample);
        ack     = TW'(i_ack_delay);
        reject  = (i_sample == '0) || (i_sample == '1);
        min_upd = ((r_min == '0) || (r_min > s)) ? s : r_min;
        adj     = ((s - min_upd) >= ack) ? (s - ack) : s;
        dist_s  = (r_srtt > adj) ? (r_srtt - adj) : (adj - r_srtt);
        dev_ewma  = {1'b0, r_dev} - {1'b0, r_dev >> BETA_SHIFT}
                    + {1'b0, dist_s >> BETA_SHIFT};
        srtt_ewma = {1'b0, r_srtt} - {1'b0, r_srtt >> ALPHA_SHIFT}
                    + {1'b0, adj >> ALPHA_SHIFT};
        dist_e  = (r_srtt > r_latest) ? (r_srtt - r_latest) : (r_latest - r_srtt);
    end

    always_comb begin
        n_min      = r_min;
        n_latest   = r_latest;
        n_srtt     = r_srtt;
        n_dev      = r_dev;
        n_has_meas = r_has_meas;
        n_taken    = 1'b0;
        case (i_op)
            OP_UPDATE: begin
                if (!reject) begin
                    n_taken  = 1'b1;
                    n_min    = min_upd;
                    n_latest = adj;
                    if (!r_has_meas) begin
                        n_has_meas = 1'b1;
                        n_srtt     = adj;
                        n_dev      = adj >> 1;
                    end else begin
                        n_srtt = srtt_ewma[TW-1:0];
                        n_dev  = dev_ewma[TW-1:0];
                    end
                end
            end
            OP_SET_INIT: begin
                n_srtt   = TW'(i_initial);
                n_latest = TW'(i_initial);
            end
            OP_MIGRATE: begin
                n_min      = '0;
                n_latest   = '0;
                n_srtt     = '0;
                n_dev      = '0;
                n_has_meas = 1'b0;
            end
            OP_EXPIRE: begin
                if (dist_e > r_dev) begin
                    n_dev = dist_e;
                end
                if (r_latest > r_srtt) begin
                    n_srtt = r_latest;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= '0;
            r_latest   <= '0;
            r_srtt     <= '0;
            r_dev      <= '0;
            r_has_meas <= 1'b0;
            r_taken    <= 1'b0;
        end else if (i_en) begin
            r_min      <= n_min;
            r_latest   <= n_latest;
            r_srtt     <= n_srtt;
            r_dev      <= n_dev;
            r_has_meas <= n_has_meas;
            r_taken    <= n_taken;
        end
    end

    assign o_min_rtt      = r_min;
    assign o_latest_rtt   = r_latest;
    assign o_smoothed_rtt = r_srtt;
    assign o_deviation    = r_dev;
    assign o_taken        = r_taken;

endmodule

FILE: rtl/rtte_pto.sv
// ----------------------------------------------------------------------------
// RTT estimator probe timeout
// Forms the probe timeout from smoothed RTT, floored four times deviation and
// optional max ACK delay, saturated to 32 bits; 2 x initial RTT if SRTT is 0.
// ----------------------------------------------------------------------------
module rtte_pto
    import rtte_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic [TIME_WIDTH-1:0] i_smoothed_rtt,
    input  logic [TIME_WIDTH-1:0] i_deviation,
    input  logic [CFG_W-1:0]      i_max_ack_delay,
    input  logic [CFG_W-1:0]      i_initial_rtt,
    input  logic                  i_include_ack_delay,
    output logic [FIELD_W-1:0]    o_pto
);

    localparam int unsigned BASE_W = (TIME_WIDTH > FIELD_W) ? TIME_WIDTH : FIELD_W;
    localparam int unsigned PW     = BASE_W + 3;

    logic [PW-1:0] var4, sum;

    always_comb begin
        var4 = PW'(i_deviation) << 2;
        if (var4 < PW'(PTO_FLOOR)) begin
            var4 = PW'(PTO_FLOOR);
        end
        sum = PW'(i_smoothed_rtt) + var4
              + (i_include_ack_delay ? PW'(i_max_ack_delay) : PW'(0));
        if (i_smoothed_rtt == '0) begin
            o_pto = FIELD_W'({i_initial_rtt, 1'b0});
        end else if (sum > PW'({FIELD_W{1'b1}})) begin
            o_pto = '1;
        end else begin
            o_pto = sum[FIELD_W-1:0];
        end
    end

endmodule

FILE: sim/tb_rtt_estimator.sv
// ----------------------------------------------------------------------------
// RTT estimator testbench
// Sends directed and random event requests through the stream input and
// compares every result with an in-bench estimator model, field by field.
// The configuration registers are rewritten between phases while the block is
// idle, and both stream sides stall at random except in the final phases.
// ----------------------------------------------------------------------------
module tb_rtt_estimator;
    import rtte_pkg::*;

    localparam int unsigned SRTT_GAIN_SHIFT   = 3;
    localparam int unsigned RTTVAR_GAIN_SHIFT = 2;
    localparam int unsigned CYCLE_LIMIT       = 100000;
    localparam int unsigned SETTLE_CYCLES     = 8;

    localparam logic [2:0]           OP_CODE_MAX    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;
    localparam logic [31:0]          TIME_MAX       = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] min_rtt;
        logic [31:0] latest_rtt;
        logic [31:0] smoothed_rtt;
        logic [31:0] deviation;
        logic [31:0] pto;
        logic        accepted;
    } t_rtt_stats;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [103:0]         i_s_tdata   = '0;
    logic [2:0]           i_s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [159:0]         o_m_tdata;
    logic [0:0]           o_m_tuser;

    logic [31:0] est_min_rtt;
    logic [31:0] est_latest_rtt;
    logic [31:0] est_smoothed_rtt;
    logic [31:0] est_deviation;
    logic        est_measured;
    logic [23:0] cfg_max_ack_delay;
    logic [23:0] cfg_initial_rtt;

    t_rtt_stats  pending_stats[$];
    t_rtt_stats  head_stats;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned stall_left   = 0;
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;

    rtt_estimator #(
        .ALPHA_SHIFT (SRTT_GAIN_SHIFT),
        .BETA_SHIFT  (RTTVAR_GAIN_SHIFT),
        .TIME_WIDTH  (32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rtt_estimator");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] rtt_gap(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_rtt_stats apply_event(input logic [2:0] op, input logic [31:0] sample,
                                               input logic [31:0] ack, input logic [31:0] init,
                                               input logic with_delay);
        t_rtt_stats  res;
        logic [31:0] adj;
        logic [31:0] gap;
        logic [63:0] dev4;
        logic [63:0] pto_sum;
        res.accepted = 1'b0;
        case (op)
            OP_UPDATE: begin
                if (sample != 32'd0 && sample != TIME_MAX) begin
                    res.accepted = 1'b1;
                    if (est_min_rtt == 32'd0 || est_min_rtt > sample)
                        est_min_rtt = sample;
                    adj = sample;
                    if (sample - est_min_rtt >= ack)
                        adj = sample - ack;
                    est_latest_rtt = adj;
                    if (!est_measured) begin
                        est_measured     = 1'b1;
                        est_smoothed_rtt = adj;
                        est_deviation    = adj >> 1;
                    end else begin
                        gap = rtt_gap(est_smoothed_rtt, adj);
                        est_deviation = est_deviation - (est_deviation >> RTTVAR_GAIN_SHIFT)
                                        + (gap >> RTTVAR_GAIN_SHIFT);
                        est_smoothed_rtt = est_smoothed_rtt - (est_smoothed_rtt >> SRTT_GAIN_SHIFT)
                                           + (adj >> SRTT_GAIN_SHIFT);
                    end
                end
            end
            OP_SET_INIT: begin
                est_smoothed_rtt = init;
                est_latest_rtt   = init;
            end
            OP_MIGRATE: begin
                est_min_rtt      = '0;
                est_latest_rtt   = '0;
                est_smoothed_rtt = '0;
                est_deviation    = '0;
                est_measured     = 1'b0;
            end
            OP_EXPIRE: begin
                gap = rtt_gap(est_smoothed_rtt, est_latest_rtt);
                if (gap > est_deviation)
                    est_deviation = gap;
                if (est_latest_rtt > est_smoothed_rtt)
                    est_smoothed_rtt = est_latest_rtt;
            end
            default: begin
            end
        endcase
        if (est_smoothed_rtt == 32'd0) begin
            pto_sum = 64'(cfg_initial_rtt) << 1;
        end else begin
            dev4 = 64'(est_deviation) << 2;
            if (dev4 < 64'(PTO_FLOOR))
                dev4 = 64'(PTO_FLOOR);
            pto_sum = 64'(est_smoothed_rtt) + dev4;
            if (with_delay)
                pto_sum = pto_sum + 64'(cfg_max_ack_delay);
        end
        res.pto          = (pto_sum > 64'(TIME_MAX)) ? TIME_MAX : pto_sum[31:0];
        res.min_rtt      = est_min_rtt;
        res.latest_rtt   = est_latest_rtt;
        res.smoothed_rtt = est_smoothed_rtt;
        res.deviation    = est_deviation;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_stats.size() == 0) begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end else begin
                head_stats = pending_stats.pop_front();
                check_field("minimum_rtt", head_stats.min_rtt, o_m_tdata[31:0]);
                check_field("latest_rtt", head_stats.latest_rtt, o_m_tdata[63:32]);
                check_field("smoothed_rtt", head_stats.smoothed_rtt, o_m_tdata[95:64]);
                check_field("rtt_deviation", head_stats.deviation, o_m_tdata[127:96]);
                check_field("probe_timeout", head_stats.pto, o_m_tdata[159:128]);
                check_field("sample_accepted", {31'd0, head_stats.accepted},
                            {31'd0, o_m_tuser[0]});
            end
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [31:0] sample,
                                input logic [31:0] ack, input logic [31:0] init,
                                input logic with_delay);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, with_delay, init, ack, sample};
        do @(posedge i_clk); while (!o_s_tready);
        pending_stats.push_back(apply_event(op, sample, ack, init, with_delay));
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MAX_ACK_DELAY)
            cfg_max_ack_delay = value;
        else if (idx == CFG_INITIAL_RTT)
            cfg_initial_rtt = value;
    endtask

    function automatic logic [CFG_W-1:0] pick_cfg_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(1, 100000));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // The boundary cases put the ACK delay exactly at, or one above, the room
    // left between the sample and the minimum RTT it will be judged against.
    function automatic logic [31:0] ack_for_sample(input logic [31:0] s);
        logic [31:0] room;
        room = (est_min_rtt == 32'd0 || est_min_rtt > s) ? 32'd0 : s - est_min_rtt;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return room;
            2: return room + 1;
            3: return $urandom_range(0, room);
            4: return $urandom;
            default: return $urandom_range(0, s >> 3);
        endcase
    endfunction

    task automatic reset_block();
        est_min_rtt       = '0;
        est_latest_rtt    = '0;
        est_smoothed_rtt  = '0;
        est_deviation     = '0;
        est_measured      = 1'b0;
        cfg_max_ack_delay = MAX_ACK_DELAY_RST;
        cfg_initial_rtt   = INITIAL_RTT_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_idle_defaults();
        send_request(OP_QUERY, $urandom, $urandom, $urandom, 1'b0);
        send_request(OP_QUERY, $urandom, $urandom, $urandom, 1'b1);
        send_request(OP_QUERY + 3'd1, $urandom, $urandom, $urandom, 1'b1);
        send_request(OP_CODE_MAX, $urandom, $urandom, $urandom, 1'b0);
    endtask

    task automatic test_sample_path();
        send_request(OP_UPDATE, 32'd0, 32'd10, $urandom, 1'b0);
        send_request(OP_UPDATE, TIME_MAX, 32'd10, $urandom, 1'b1);
        send_request(OP_UPDATE, 32'd100000, 32'd5000, $urandom, 1'b0);
        send_request(OP_UPDATE, 32'd120000, 32'd10000, $urandom, 1'b1);
        send_request(OP_UPDATE, 32'd1, 32'd0, $urandom, 1'b0);
        send_request(OP_UPDATE, 32'hFFFF_FFFE, TIME_MAX, $urandom, 1'b0);
        send_request(OP_UPDATE, 32'hFFFF_FFFE, 32'd0, $urandom, 1'b1);
        send_request(OP_EXPIRE, $urandom, $urandom, $urandom, 1'b1);
        send_request(OP_SET_INIT, $urandom, $urandom, 32'd0, 1'b1);
        send_request(OP_SET_INIT, $urandom, $urandom, TIME_MAX, 1'b1);
        send_request(OP_UPDATE, 32'd50, 32'd0, $urandom, 1'b0);
        send_request(OP_EXPIRE, $urandom, $urandom, $urandom, 1'b0);
        send_request(OP_MIGRATE, $urandom, $urandom, $urandom, 1'b0);
        send_request(OP_UPDATE, 32'd2, 32'd0, $urandom, 1'b0);
        send_request(OP_UPDATE, 32'd3, 32'd1, $urandom, 1'b1);
        send_request(OP_QUERY + 3'd2, $urandom, $urandom, $urandom, 1'b1);
    endtask

    task automatic test_config_registers();
        wait_idle();
        write_register(CFG_MAX_ACK_DELAY, '0);
        write_register(CFG_INITIAL_RTT, '0);
        send_request(OP_MIGRATE, $urandom, $urandom, $urandom, 1'b1);
        send_request(OP_UPDATE, 32'd5000, 32'd0, $urandom, 1'b1);
        wait_idle();
        write_register(CFG_MAX_ACK_DELAY, '1);
        write_register(CFG_INITIAL_RTT, '1);
        send_request(OP_QUERY, $urandom, $urandom, $urandom, 1'b1);
        send_request(OP_MIGRATE, $urandom, $urandom, $urandom, 1'b1);
        wait_idle();
        write_register(CFG_IDX_SPARE0, 24'h5A5A5A);
        write_register(CFG_IDX_SPARE1, 24'hA5A5A5);
        write_register(CFG_INITIAL_RTT, 24'd1);
        send_request(OP_QUERY, $urandom, $urandom, $urandom, 1'b0);
    endtask

    // Most requests follow one connection: samples around a base RTT with
    // occasional resets and expiries; the rest are noise across all codes.
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [31:0] base;
        logic [31:0] s;
        logic [31:0] a;
        logic [31:0] iv;
        logic [2:0]  op;
        logic        inc;
        int          pick;
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            repeat ($urandom_range(1, 3))
                write_register(CFG_IDX_W'($urandom_range(0, 3)), pick_cfg_value());
            if (p >= phases - 2) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end else begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            base = 32'd1 + ($urandom >> $urandom_range(1, 31));
            for (int n = 0; n < per_phase; n++) begin
                s    = $urandom;
                a    = $urandom;
                iv   = $urandom;
                inc  = 1'($urandom_range(0, 1));
                op   = OP_QUERY;
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    op = OP_UPDATE;
                    s  = base + $urandom_range(0, base >> 2);
                    a  = ack_for_sample(s);
                end else if (pick < 74) begin
                    op = OP_UPDATE;
                    case ($urandom_range(0, 3))
                        0: s = '0;
                        1: s = TIME_MAX;
                        2: s = 32'hFFFF_FFFE;
                        default: s = $urandom;
                    endcase
                end else if (pick < 79) begin
                    op = OP_SET_INIT;
                    if ($urandom_range(0, 1) == 0)
                        iv = base + $urandom_range(0, base >> 1);
                end else if (pick < 85) begin
                    op = OP_EXPIRE;
                end else if (pick < 88) begin
                    op = OP_MIGRATE;
                end else if (pick < 94) begin
                    op = 3'($urandom_range(OP_QUERY, OP_CODE_MAX));
                end else begin
                    op = 3'($urandom_range(OP_UPDATE, OP_CODE_MAX));
                end
                send_request(op, s, a, iv, inc);
            end
        end
    endtask

    task automatic finish_run();
        wait_idle();
        if (fail_count == 0) begin
            $display("PASS rtt_estimator");
        end else begin
            $display("FAIL rtt_estimator");
        end
        $finish;
    endtask

    initial begin
        reset_block();
        test_idle_defaults();
        test_sample_path();
        test_config_registers();
        test_random_traffic(10, 130);
        finish_run();
    end

endmodule
